@@ hdl/motor_command_packet_framer_defines.svh @@
// Assertion macros shared by the motor command packet framer RTL.
`ifndef MOTOR_COMMAND_PACKET_FRAMER_DEFINES_SVH
`define MOTOR_COMMAND_PACKET_FRAMER_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define MCPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define MCPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mcpf_pkg.sv @@
// Types, constants and helper functions of the motor command packet framer.
package mcpf_pkg;

    localparam int unsigned IN_W  = 80;
    localparam int unsigned OUT_W = 8;

    localparam logic [1:0] CMD_SPEED = 2'd0;
    localparam logic [1:0] CMD_POS   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_GET   = 2'd3;

    localparam logic [7:0] NUM_MOVE  = 8'd36;
    localparam logic [7:0] NUM_START = 8'd32;
    localparam logic [7:0] NUM_GET   = 8'd35;

    localparam logic [7:0] TAG_SPEED = 8'd2;
    localparam logic [7:0] TAG_POS   = 8'd1;
    localparam logic [7:0] TAG_LIMIT = 8'd2;

    localparam logic [7:0] PARAM_A = 8'd1;
    localparam logic [7:0] PARAM_B = 8'd2;

    localparam logic [7:0]  UNIT_ADDR_RST = 8'd128;
    localparam logic [13:0] CRC_INIT      = 14'h3fff;
    localparam logic [13:0] CRC_XOROUT    = 14'h3fff;
    localparam logic [13:0] CRC_POLY      = 14'h22f0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_NUM,
        ST_LEN,
        ST_CHAN,
        ST_ZERO,
        ST_TAG,
        ST_MV,
        ST_TAG2,
        ST_LIM,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_ERR
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic   capture;
        logic   load;
        t_state sel;
        logic   last;
        logic   bad;
        logic   grp_clr;
        logic   grp_inc;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       room;
        logic       in_bad;
        logic [1:0] cmd;
        logic       lim_on;
        logic       mv_last;
        logic       lim_last;
    } t_stat;

    // One CRC step over the 7 low bits of a byte, LSB first.
    function automatic logic [13:0] crc_fold(input logic [13:0] crc, input logic [7:0] b);
        logic [13:0] c;
        c = crc ^ {7'd0, b[6:0]};
        for (int i = 0; i < 7; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Sign-magnitude code: magnitude << 1, sign in bit 0.
    function automatic logic [30:0] pack_code(input logic [29:0] v);
        logic [29:0] mag;
        mag = 30'd0 - v;
        return v[29] ? {mag, 1'b1} : {1'b0, v[28:0], 1'b0};
    endfunction

    // Number of 6-bit groups sent for a code, 1..5.
    function automatic logic [2:0] pack_groups(input logic [30:0] code);
        logic [2:0] n;
        priority if (|code[30:24]) n = 3'd5;
        else if (|code[23:18])     n = 3'd4;
        else if (|code[17:12])     n = 3'd3;
        else if (|code[11:6])      n = 3'd2;
        else                       n = 3'd1;
        return n;
    endfunction

endpackage

@@ hdl/mcpf_ctrl.sv @@
// Byte sequencer state machine of the packet framer.
module mcpf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_valid,
    output logic            o_s_ready,
    input  mcpf_pkg::t_stat i_stat,
    output mcpf_pkg::t_cmd  o_cmd
);

    mcpf_pkg::t_state r_state;
    mcpf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcpf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.sel       = r_state;
        o_cmd.load      = (r_state != mcpf_pkg::ST_IDLE) && i_stat.room;
        o_s_ready       = (r_state == mcpf_pkg::ST_IDLE);

        unique case (r_state)
            mcpf_pkg::ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_stat.in_bad ? mcpf_pkg::ST_ERR : mcpf_pkg::ST_ADDR;
                end
            end
            mcpf_pkg::ST_ADDR: if (o_cmd.load) n_state = mcpf_pkg::ST_NUM;
            mcpf_pkg::ST_NUM:  if (o_cmd.load) n_state = mcpf_pkg::ST_LEN;
            mcpf_pkg::ST_LEN:  if (o_cmd.load) n_state = mcpf_pkg::ST_CHAN;
            mcpf_pkg::ST_CHAN: if (o_cmd.load) n_state = mcpf_pkg::ST_ZERO;
            mcpf_pkg::ST_ZERO: begin
                if (o_cmd.load) begin
                    n_state = (i_stat.cmd == mcpf_pkg::CMD_START) ? mcpf_pkg::ST_CRC_LO
                                                                   : mcpf_pkg::ST_TAG;
                end
            end
            mcpf_pkg::ST_TAG: begin
                if (o_cmd.load) begin
                    n_state = (i_stat.cmd == mcpf_pkg::CMD_GET) ? mcpf_pkg::ST_CRC_LO
                                                                 : mcpf_pkg::ST_MV;
                end
            end
            mcpf_pkg::ST_MV: begin
                if (o_cmd.load) begin
                    if (i_stat.mv_last) begin
                        o_cmd.grp_clr = 1'b1;
                        n_state = (i_stat.cmd == mcpf_pkg::CMD_POS && i_stat.lim_on)
                                  ? mcpf_pkg::ST_TAG2 : mcpf_pkg::ST_CRC_LO;
                    end else begin
                        o_cmd.grp_inc = 1'b1;
                    end
                end
            end
            mcpf_pkg::ST_TAG2: if (o_cmd.load) n_state = mcpf_pkg::ST_LIM;
            mcpf_pkg::ST_LIM: begin
                if (o_cmd.load) begin
                    if (i_stat.lim_last) begin
                        o_cmd.grp_clr = 1'b1;
                        n_state = mcpf_pkg::ST_CRC_LO;
                    end else begin
                        o_cmd.grp_inc = 1'b1;
                    end
                end
            end
            mcpf_pkg::ST_CRC_LO: if (o_cmd.load) n_state = mcpf_pkg::ST_CRC_HI;
            mcpf_pkg::ST_CRC_HI: begin
                o_cmd.last = 1'b1;
                if (o_cmd.load) n_state = mcpf_pkg::ST_IDLE;
            end
            mcpf_pkg::ST_ERR: begin
                o_cmd.last = 1'b1;
                o_cmd.bad  = 1'b1;
                if (o_cmd.load) n_state = mcpf_pkg::ST_IDLE;
            end
            default: n_state = mcpf_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ hdl/mcpf_dp.sv @@
// Field registers, byte select, CRC and output register of the packet framer.
module mcpf_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [7:0]                  i_cfg_wdata,
    input  logic [mcpf_pkg::IN_W-1:0]   i_in_data,
    input  mcpf_pkg::t_cmd              i_cmd,
    output mcpf_pkg::t_stat             o_stat,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [mcpf_pkg::OUT_W-1:0]  o_out_byte,
    output logic                        o_out_last,
    output logic                        o_out_bad
);

    logic [1:0]  in_cmd;
    logic [7:0]  in_chan;
    logic [29:0] in_mv;
    logic [29:0] in_lim;
    logic [7:0]  in_param;

    assign in_cmd   = i_in_data[1:0];
    assign in_chan  = i_in_data[9:2];
    assign in_mv    = i_in_data[39:10];
    assign in_lim   = i_in_data[69:40];
    assign in_param = i_in_data[77:70];

    logic [7:0]  r_unit_addr;
    logic [1:0]  r_cmd;
    logic [7:0]  r_chan;
    logic [7:0]  r_param;
    logic [30:0] r_mv_sh;
    logic [30:0] r_lim_sh;
    logic [2:0]  r_mv_n;
    logic [2:0]  r_lim_n;
    logic        r_lim_on;
    logic [2:0]  r_grp;
    logic [13:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_bad;

    logic [30:0] mv_code;
    logic [30:0] lim_code;
    logic [7:0]  pay_len;
    logic [7:0]  n_byte;
    logic [13:0] crc_out;

    assign mv_code  = mcpf_pkg::pack_code(in_mv);
    assign lim_code = mcpf_pkg::pack_code(in_lim);
    assign crc_out  = r_crc ^ mcpf_pkg::CRC_XOROUT;

    // channel and zero flags, then per-command payload
    always_comb begin
        unique case (r_cmd)
            mcpf_pkg::CMD_SPEED: pay_len = 8'd3 + {5'd0, r_mv_n};
            mcpf_pkg::CMD_POS:   pay_len = 8'd3 + {5'd0, r_mv_n}
                                         + (r_lim_on ? 8'd1 + {5'd0, r_lim_n} : 8'd0);
            mcpf_pkg::CMD_START: pay_len = 8'd2;
            mcpf_pkg::CMD_GET:   pay_len = 8'd3;
            default:             pay_len = 8'd2;
        endcase
    end

    always_comb begin
        n_byte = 8'd0;
        unique case (i_cmd.sel)
            mcpf_pkg::ST_ADDR: n_byte = r_unit_addr;
            mcpf_pkg::ST_NUM: begin
                unique case (r_cmd)
                    mcpf_pkg::CMD_START: n_byte = mcpf_pkg::NUM_START;
                    mcpf_pkg::CMD_GET:   n_byte = mcpf_pkg::NUM_GET;
                    default:             n_byte = mcpf_pkg::NUM_MOVE;
                endcase
            end
            mcpf_pkg::ST_LEN:  n_byte = pay_len;
            mcpf_pkg::ST_CHAN: n_byte = r_chan;
            mcpf_pkg::ST_TAG: begin
                unique case (r_cmd)
                    mcpf_pkg::CMD_SPEED: n_byte = mcpf_pkg::TAG_SPEED;
                    mcpf_pkg::CMD_POS:   n_byte = mcpf_pkg::TAG_POS;
                    default:             n_byte = r_param;
                endcase
            end
            mcpf_pkg::ST_MV:     n_byte = {1'b0, |r_mv_sh[30:6], r_mv_sh[5:0]};
            mcpf_pkg::ST_TAG2:   n_byte = mcpf_pkg::TAG_LIMIT;
            mcpf_pkg::ST_LIM:    n_byte = {1'b0, |r_lim_sh[30:6], r_lim_sh[5:0]};
            mcpf_pkg::ST_CRC_LO: n_byte = {1'b0, crc_out[6:0]};
            mcpf_pkg::ST_CRC_HI: n_byte = {1'b0, crc_out[13:7]};
            default:             n_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_addr <= mcpf_pkg::UNIT_ADDR_RST;
        end else if (i_cfg_we) begin
            r_unit_addr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= in_cmd;
            r_chan   <= in_chan;
            r_param  <= in_param;
            r_mv_sh  <= mv_code;
            r_lim_sh <= lim_code;
            r_mv_n   <= mcpf_pkg::pack_groups(mv_code);
            r_lim_n  <= mcpf_pkg::pack_groups(lim_code);
            r_lim_on <= ~in_lim[29];
            r_crc    <= mcpf_pkg::CRC_INIT;
        end else if (i_cmd.load) begin
            if (i_cmd.sel == mcpf_pkg::ST_MV) r_mv_sh <= r_mv_sh >> 6;
            if (i_cmd.sel == mcpf_pkg::ST_LIM) r_lim_sh <= r_lim_sh >> 6;
            if (i_cmd.sel != mcpf_pkg::ST_CRC_LO && i_cmd.sel != mcpf_pkg::ST_CRC_HI
                    && i_cmd.sel != mcpf_pkg::ST_ERR) begin
                r_crc <= mcpf_pkg::crc_fold(r_crc, n_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= 3'd0;
        end else if (i_cmd.capture || i_cmd.grp_clr) begin
            r_grp <= 3'd0;
        end else if (i_cmd.grp_inc) begin
            r_grp <= r_grp + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_byte <= n_byte;
            r_out_last <= i_cmd.last;
            r_out_bad  <= i_cmd.bad;
        end
    end

    always_comb begin
        o_stat.room     = !r_out_valid || i_out_ready;
        o_stat.in_bad   = (in_cmd == mcpf_pkg::CMD_GET)
                          && !(in_param == mcpf_pkg::PARAM_A || in_param == mcpf_pkg::PARAM_B);
        o_stat.cmd      = r_cmd;
        o_stat.lim_on   = r_lim_on;
        o_stat.mv_last  = (r_grp == r_mv_n - 3'd1);
        o_stat.lim_last = (r_grp == r_lim_n - 3'd1);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_bad   = r_out_bad;

endmodule

@@ hdl/motor_command_packet_framer.sv @@
// The input beat is captured and the sequencer leaves idle; each byte goes into
// the single output register once it has room. Throughput: one packet byte per
// cycle while the output is ready; a packet is 7 to 19 bytes, a bad get request
// one error beat, paced by the byte sequencer, which takes no new beat until idle.
// Reset: sequencer idle, output empty, unit address 128.
`include "motor_command_packet_framer_defines.svh"

module motor_command_packet_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], channel[9:2], move_value[39:10], speed_limit[69:40],
    // get_parameter[77:70], zero pad [79:78]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // bad_request
    output logic        m_axis_tuser
);

    mcpf_pkg::t_cmd  w_cmd;
    mcpf_pkg::t_stat w_stat;

    mcpf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    mcpf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_bad   (m_axis_tuser)
    );

    `MCPF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input beat taken while packet in flight")
    `MCPF_ASSERT_NOW(a_bad_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "error beat without tlast")
    `MCPF_ASSERT_NOW(a_load_has_room, w_cmd.load, w_stat.room, "output register overwritten")
    `MCPF_ASSERT_NOW(a_crc_hi_last, w_cmd.load && w_cmd.sel == mcpf_pkg::ST_CRC_HI, w_cmd.last, "crc high byte not marked last")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the motor command packet framer: directed and random commands.
module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;

    // Packed so that the struct lines up with s_axis_tdata[77:0], cmd in the low bits.
    typedef struct packed {
        logic [7:0]  param;
        logic [29:0] lim;
        logic [29:0] mv;
        logic [7:0]  chan;
        logic [1:0]  cmd;
    } t_motor_req;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_pkt_beat;

    logic                        i_clk;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_we      = 1'b0;
    logic [7:0]                  i_cfg_wdata   = 8'd0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [mcpf_pkg::IN_W-1:0]   s_axis_tdata  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [mcpf_pkg::OUT_W-1:0]  m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        m_axis_tuser;

    t_motor_req  pending_reqs[$];
    t_pkt_beat   expected_beats[$];
    logic [7:0]  frame_q[$];
    logic [7:0]  unit_addr_model = mcpf_pkg::UNIT_ADDR_RST;

    int send_idle_max = 0;
    int recv_idle_max = 0;
    int send_wait     = 0;
    int recv_wait     = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int fail_count    = 0;
    int beats_checked = 0;
    int bad_seen      = 0;
    int longest_pkt   = 0;
    int cmd_seen[4]   = '{0, 0, 0, 0};
    t_pkt_beat got_want;

    motor_command_packet_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sign-magnitude code in 6-bit groups, bit 6 set while 0x40 or more remains.
    function automatic void append_move(input logic [29:0] v);
        logic [31:0] code;
        bit          done;
        code = v[29] ? {1'b0, 30'd0 - v, 1'b1} : {1'b0, v, 1'b0};
        done = 1'b0;
        for (int n = 0; n < 5; n++) begin
            if (!done) begin
                frame_q.push_back({1'b0, code >= 32'h40, code[5:0]});
                code = code >> 6;
                done = (code == 0);
            end
        end
    endfunction

    function automatic logic [13:0] frame_crc();
        logic [13:0] c;
        c = mcpf_pkg::CRC_INIT;
        foreach (frame_q[i]) begin
            c = c ^ {7'd0, frame_q[i][6:0]};
            repeat (7) c = c[0] ? ((c >> 1) ^ mcpf_pkg::CRC_POLY) : (c >> 1);
        end
        return c ^ mcpf_pkg::CRC_XOROUT;
    endfunction

    function automatic void predict_packet(input t_motor_req r);
        t_pkt_beat   b;
        logic [13:0] crc;
        frame_q.delete();
        cmd_seen[r.cmd]++;
        if (r.cmd == mcpf_pkg::CMD_GET && r.param != mcpf_pkg::PARAM_A
                && r.param != mcpf_pkg::PARAM_B) begin
            b.data = 8'd0;
            b.last = 1'b1;
            b.bad  = 1'b1;
            expected_beats.push_back(b);
            bad_seen++;
        end else begin
            frame_q.push_back(unit_addr_model);
            frame_q.push_back(mcpf_pkg::NUM_MOVE);
            frame_q.push_back(8'd0);    // length, filled in below
            frame_q.push_back(r.chan);
            frame_q.push_back(8'd0);
            case (r.cmd)
                mcpf_pkg::CMD_SPEED: begin
                    frame_q.push_back(mcpf_pkg::TAG_SPEED);
                    append_move(r.mv);
                end
                mcpf_pkg::CMD_POS: begin
                    frame_q.push_back(mcpf_pkg::TAG_POS);
                    append_move(r.mv);
                    if (!r.lim[29]) begin
                        frame_q.push_back(mcpf_pkg::TAG_LIMIT);
                        append_move(r.lim);
                    end
                end
                mcpf_pkg::CMD_START: frame_q[1] = mcpf_pkg::NUM_START;
                default: begin
                    frame_q[1] = mcpf_pkg::NUM_GET;
                    frame_q.push_back(r.param);
                end
            endcase
            frame_q[2] = 8'(frame_q.size() - 3);
            crc = frame_crc();
            frame_q.push_back({1'b0, crc[6:0]});
            frame_q.push_back({1'b0, crc[13:7]});
            foreach (frame_q[k]) begin
                b.data = frame_q[k];
                b.last = (k == frame_q.size() - 1);
                b.bad  = 1'b0;
                expected_beats.push_back(b);
            end
            if (frame_q.size() > longest_pkt)
                longest_pkt = frame_q.size();
        end
    endfunction

    function automatic t_motor_req mk_req(input logic [1:0] cmd, input logic [7:0] chan,
                                          input logic [29:0] mv, input logic [29:0] lim,
                                          input logic [7:0] param);
        t_motor_req r;
        r.cmd   = cmd;
        r.chan  = chan;
        r.mv    = mv;
        r.lim   = lim;
        r.param = param;
        return r;
    endfunction

    function automatic logic [29:0] random_value();
        logic [29:0] m;
        case ($urandom_range(4, 0))
            0: m = 30'($urandom_range(70, 0));
            1: m = 30'($urandom_range(1 << 17, 0));
            2: m = 30'($urandom);
            3: begin
                case ($urandom_range(3, 0))
                    0: m = 30'h1fffffff;
                    1: m = 30'h20000001;
                    2: m = 30'h20000000;
                    default: m = 30'h3fffffff;
                endcase
            end
            default: m = 30'($urandom_range(1 << 23, 0));
        endcase
        if ($urandom_range(1, 0))
            m = 30'd0 - m;
        return m;
    endfunction

    function automatic t_motor_req random_req();
        t_motor_req  r;
        logic [29:0] v;
        r.cmd = 2'($urandom_range(3, 0));
        case ($urandom_range(5, 0))
            0: r.chan = "1";
            1: r.chan = "2";
            2: r.chan = "D";
            3: r.chan = "T";
            default: r.chan = 8'($urandom);
        endcase
        r.mv = random_value();
        v = random_value();
        // a quarter of the limits are negative and get dropped from the packet
        r.lim = ($urandom_range(3, 0) == 0) ? (30'h20000000 | 30'($urandom)) : {1'b0, v[28:0]};
        r.param = ($urandom_range(3, 0) != 0) ? 8'($urandom_range(2, 1)) : 8'($urandom);
        return r;
    endfunction

    // Sender: one item per beat, random gap before the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_packet(t_motor_req'(s_axis_tdata[77:0]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_axis_tdata  <= {2'b00, pending_reqs.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    send_wait = $urandom_range(send_idle_max, 0);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each beat, stalls at random and on a hold-off request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected beat: out_byte %0h last_byte %0b bad_request %0b",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    fail_count++;
                end else begin
                    got_want = expected_beats.pop_front();
                    beats_checked++;
                    if (m_axis_tdata !== got_want.data) begin
                        $error("out_byte: expected %0h, got %0h", got_want.data, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== got_want.last) begin
                        $error("last_byte: expected %0b, got %0b", got_want.last, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tuser !== got_want.bad) begin
                        $error("bad_request: expected %0b, got %0b", got_want.bad, m_axis_tuser);
                        fail_count++;
                    end
                end
                recv_wait = $urandom_range(recv_idle_max, 0);
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_address(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        unit_addr_model = v;
        @(negedge i_clk);
    endtask

    task automatic run_random(input logic [7:0] addr, input int count, input int s_max,
                              input int r_max, input bit hold_off);
        write_address(addr);
        send_idle_max = s_max;
        recv_idle_max = r_max;
        if (hold_off)
            hold_token++;
        repeat (count) pending_reqs.push_back(random_req());
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: value packing edges, limit present or dropped, every command, bad gets
        write_address(8'd0);
        send_idle_max = 16;
        recv_idle_max = 16;
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_SPEED, "1", 30'd0, 30'h3fffffff, 8'hff));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_SPEED, "2", 30'd31, 30'd0, 8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_SPEED, "D", 30'd32, 30'd0, 8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_SPEED, "T", 30'h3fffffff, 30'd0, 8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_SPEED, "1", 30'h1fffffff, 30'd0, 8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_SPEED, "1", 30'h20000001, 30'd0, 8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_SPEED, "2", 30'h20000000, 30'h1fffffff,
                                      8'd7));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_POS, "1", 30'd100, 30'h3fffffff, 8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_POS, 8'hff, 30'h20000000, 30'h1fffffff,
                                      8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_POS, "D", 30'h1fffffff, 30'd0, 8'hff));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_POS, "T", 30'h3ffffffb, 30'h20000000,
                                      8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_POS, 8'd0, 30'h20000001, 30'd63, 8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_START, 8'd0, 30'd0, 30'd0, 8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_START, 8'hff, 30'h3fffffff, 30'h3fffffff,
                                      8'hff));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_GET, "D", 30'd0, 30'd0,
                                      mcpf_pkg::PARAM_A));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_GET, "T", 30'h3fffffff, 30'h3fffffff,
                                      mcpf_pkg::PARAM_B));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_GET, "1", 30'd0, 30'd0, 8'd0));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_GET, "2", 30'd0, 30'd0, 8'd3));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_GET, 8'hff, 30'd0, 30'd0, 8'hff));
        pending_reqs.push_back(mk_req(mcpf_pkg::CMD_GET, 8'd0, 30'd0, 30'd0,
                                      mcpf_pkg::PARAM_A));
        wait_drained();

        run_random(8'hff, 150, 0, 0, 1'b0);
        run_random(8'($urandom), 150, 16, 16, 1'b1);
        run_random(mcpf_pkg::UNIT_ADDR_RST, 150, 0, 16, 1'b0);

        repeat (20) @(negedge i_clk);
        $display("Ran %0d speed, %0d position, %0d start and %0d get commands (%0d rejected)",
                 cmd_seen[mcpf_pkg::CMD_SPEED], cmd_seen[mcpf_pkg::CMD_POS],
                 cmd_seen[mcpf_pkg::CMD_START], cmd_seen[mcpf_pkg::CMD_GET], bad_seen);
        $display("Checked %0d beats over four unit addresses; longest packet %0d bytes",
                 beats_checked, longest_pkt);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/mcpf_pkg.sv
hdl/mcpf_ctrl.sv
hdl/mcpf_dp.sv
hdl/motor_command_packet_framer.sv
tb/tb_top.sv
